[hw/rtl/mtf_pkg.sv]
// shared constants and types for the move-to-front escape encoder
package mtf_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int SYM_W     = 8;
  localparam int ACT_W     = 9;
  localparam int POS_W     = 8;

  // search tree: groups of GRP_SIZE cells, then a pick among groups
  localparam int GRP_W     = 4;
  localparam int GRP_SIZE  = 1 << GRP_W;
  localparam int NGRP      = (MAX_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NGRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_SLOTS = NGRP * GRP_SIZE;

  // configuration register indexes
  localparam logic [1:0] REG_ACTIVE_SLOTS    = 2'd0;
  localparam logic [1:0] REG_INSERT_POSITION = 2'd1;
  localparam logic [1:0] REG_MAX_STEP        = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [SLOT_W-1:0] lo;
    logic [SLOT_W-1:0] hi;
    logic [SLOT_W-1:0] last;
    logic              shift;
  } cell_cmd_t;

endpackage

[hw/rtl/mtf_cell.sv]
// one table slot: holds an entry, compares it and on a shift takes the command symbol or its left neighbor
module mtf_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mtf_pkg::SLOT_W-1:0]   cell_idx,
  input  mtf_pkg::cell_cmd_t           cmd,
  input  logic [mtf_pkg::SYM_W-1:0]    left_entry,
  output logic [mtf_pkg::SYM_W-1:0]    entry_r,
  output logic                         match_r
);

  logic [mtf_pkg::SYM_W-1:0] entry_nxt;
  logic                      match_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift) begin
      if (cell_idx == cmd.lo) begin
        entry_nxt = cmd.sym;
      end else if ((cell_idx > cmd.lo) && (cell_idx <= cmd.hi)) begin
        entry_nxt = left_entry;
      end
    end
    match_nxt = (entry_r == cmd.sym) && (cell_idx <= cmd.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= mtf_pkg::SYM_W'(cell_idx);
    end else begin
      entry_r <= entry_nxt;
    end
    match_r <= match_nxt;
  end

endmodule

[hw/rtl/mtf_prio.sv]
// two-stage registered search for the lowest matching slot
module mtf_prio (
  input  logic                         clk,
  input  logic [mtf_pkg::MAX_SLOTS-1:0] match,
  output logic                         found_r,
  output logic [mtf_pkg::SLOT_W-1:0]   pos_r
);

  logic [mtf_pkg::PAD_SLOTS-1:0] match_pad;
  logic [mtf_pkg::NGRP-1:0]      grp_any_nxt;
  logic [mtf_pkg::NGRP-1:0]      grp_any_r;
  logic [mtf_pkg::GRP_W-1:0]     grp_idx_nxt [mtf_pkg::NGRP];
  logic [mtf_pkg::GRP_W-1:0]     grp_idx_r   [mtf_pkg::NGRP];
  logic                          found_nxt;
  logic [mtf_pkg::NGRP_W-1:0]    sel_grp;
  logic [mtf_pkg::NGRP_W+mtf_pkg::GRP_W-1:0] pos_full;

  assign match_pad = mtf_pkg::PAD_SLOTS'(match);

  // lowest match inside each group
  always_comb begin
    for (int g = 0; g < mtf_pkg::NGRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_idx_nxt[g] = '0;
      for (int i = mtf_pkg::GRP_SIZE - 1; i >= 0; i--) begin
        if (match_pad[g*mtf_pkg::GRP_SIZE + i]) begin
          grp_any_nxt[g] = 1'b1;
          grp_idx_nxt[g] = mtf_pkg::GRP_W'(i);
        end
      end
    end
  end

  // lowest group with a match
  always_comb begin
    found_nxt = 1'b0;
    sel_grp   = '0;
    for (int g = mtf_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found_nxt = 1'b1;
        sel_grp   = mtf_pkg::NGRP_W'(g);
      end
    end
    pos_full = {sel_grp, grp_idx_r[sel_grp]};
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    grp_idx_r <= grp_idx_nxt;
    found_r   <= found_nxt;
    pos_r     <= mtf_pkg::SLOT_W'(pos_full);
  end

endmodule

[hw/rtl/mtf_escape_encoder.sv]
// top level: move-to-front encoder with escape over a row of slot cells
//
//  channel  ports                       contents
//  input    in_tvalid/in_tready/in_tdata   symbol
//  output   out_tvalid/out_tready/out_*    code in tdata, escaped in tuser
//  config   cfg_we/cfg_idx/cfg_wdata       active_slots, insert_position, max_step
//
// an item passes from accept to result through cell compare, two stages of the
// match search tree, shift planning, then the cell row shift that loads the result.
// one item is in work at a time, so a new item is accepted only after the previous
// one has left the shift step, even while its result still waits in the output register.
// a stalled output holds the finished item in its last step until taken.
// reset is synchronous; it loads the identity order into the cells.
module mtf_escape_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] code
  output logic       out_tuser,  // [0] escaped
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [8:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_CMP, S_GRP, S_SEL, S_PLAN, S_SHIFT
  } state_t;

  state_t state_r;

  logic [mtf_pkg::ACT_W-1:0]  active_slots_r;
  logic [mtf_pkg::POS_W-1:0]  insert_position_r;
  logic [mtf_pkg::POS_W-1:0]  max_step_r;

  logic [mtf_pkg::SYM_W-1:0]  sym_r;
  logic [mtf_pkg::SLOT_W-1:0] lo_r, lo_nxt;
  logic [mtf_pkg::SLOT_W-1:0] hi_r, hi_nxt;
  logic [mtf_pkg::SYM_W-1:0]  code_r, code_nxt;
  logic                       esc_r;
  logic                       out_valid_r;
  logic [mtf_pkg::SYM_W-1:0]  out_code_r;
  logic                       out_esc_r;

  logic [mtf_pkg::SLOT_W-1:0] n_last;
  logic                       out_free;
  logic                       shift_en;
  logic                       in_acc;

  mtf_pkg::cell_cmd_t         cmd;
  logic [mtf_pkg::SYM_W-1:0]  entry [mtf_pkg::MAX_SLOTS];
  logic [mtf_pkg::MAX_SLOTS-1:0] match;
  logic                       found_r;
  logic [mtf_pkg::SLOT_W-1:0] pos_r;

  logic [mtf_pkg::ACT_W-1:0]  pos9;
  logic [mtf_pkg::ACT_W-1:0]  step9;
  logic [mtf_pkg::ACT_W-1:0]  ins9;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tuser  = out_esc_r;
  assign out_free   = !out_valid_r || out_tready;
  assign shift_en   = (state_r == S_SHIFT) && out_free;

  // last searched slot, with zero treated as one and large values saturated
  always_comb begin
    if (active_slots_r == '0) begin
      n_last = '0;
    end else if (active_slots_r > mtf_pkg::ACT_W'(mtf_pkg::MAX_SLOTS)) begin
      n_last = mtf_pkg::SLOT_W'(mtf_pkg::MAX_SLOTS - 1);
    end else begin
      n_last = mtf_pkg::SLOT_W'(active_slots_r - mtf_pkg::ACT_W'(1));
    end
  end

  // shift window for a found symbol or an escaped insert
  always_comb begin
    pos9  = mtf_pkg::ACT_W'(pos_r);
    step9 = mtf_pkg::ACT_W'(max_step_r);
    ins9  = mtf_pkg::ACT_W'(insert_position_r);
    if (found_r) begin
      hi_nxt   = pos_r;
      code_nxt = mtf_pkg::SYM_W'(pos_r);
      if ((max_step_r != '0) && (pos9 > step9)) begin
        lo_nxt = mtf_pkg::SLOT_W'(pos9 - step9);
      end else begin
        lo_nxt = '0;
      end
    end else begin
      hi_nxt   = n_last;
      code_nxt = sym_r;
      if (ins9 > mtf_pkg::ACT_W'(n_last)) begin
        lo_nxt = n_last;
      end else begin
        lo_nxt = mtf_pkg::SLOT_W'(insert_position_r);
      end
    end
  end

  always_comb begin
    cmd.sym   = sym_r;
    cmd.lo    = lo_r;
    cmd.hi    = hi_r;
    cmd.last  = n_last;
    cmd.shift = shift_en;
  end

  for (genvar i = 0; i < mtf_pkg::MAX_SLOTS; i++) begin : g_cell
    logic [mtf_pkg::SYM_W-1:0] left_entry;
    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_rest
      assign left_entry = entry[i-1];
    end
    mtf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (mtf_pkg::SLOT_W'(i)),
      .cmd        (cmd),
      .left_entry (left_entry),
      .entry_r    (entry[i]),
      .match_r    (match[i])
    );
  end

  mtf_prio u_prio (
    .clk     (clk),
    .match   (match),
    .found_r (found_r),
    .pos_r   (pos_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slots_r    <= mtf_pkg::ACT_W'(256);
      insert_position_r <= '0;
      max_step_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mtf_pkg::REG_ACTIVE_SLOTS:    active_slots_r    <= cfg_wdata;
        mtf_pkg::REG_INSERT_POSITION: insert_position_r <= cfg_wdata[7:0];
        mtf_pkg::REG_MAX_STEP:        max_step_r        <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (shift_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE:  if (in_acc) state_r <= S_CMP;
        S_CMP:   state_r <= S_GRP;
        S_GRP:   state_r <= S_SEL;
        S_SEL:   state_r <= S_PLAN;
        S_PLAN:  state_r <= S_SHIFT;
        S_SHIFT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (in_acc) begin
      sym_r <= in_tdata;
    end
    if (state_r == S_PLAN) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      code_r <= code_nxt;
      esc_r  <= !found_r;
    end
    if (shift_en) begin
      out_code_r <= code_r;
      out_esc_r  <= esc_r;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted again while an item is in work");

  a_shift_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |=> out_tvalid)
    else $error("table shifted without a result being loaded");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (lo_r <= hi_r))
    else $error("shift window start lies past its end");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("block not idle after reset");

endmodule
